>>> rtl/core/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define APBS_CHECK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define APBS_CHECK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/apbs_pkg.sv
// Shared types and constants of the aging priority belt scheduler.
`default_nettype none
package apbs_pkg;

  localparam int WAIT_DEPTH_DEF = 16;
  localparam int BELT_DEPTH_DEF = 8;

  localparam logic [15:0] DWELL_RST   = 16'd550;
  localparam logic [19:0] STARVE_RST  = 20'd6000;
  localparam logic [3:0]  CAP_RST     = 4'd5;
  localparam logic [15:0] MOVE_RST    = 16'd420;
  localparam logic [15:0] PROCESS_RST = 16'd270;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STARVE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS = 3'd4;

  localparam int PKG_W   = 41;
  localparam int BELT_W  = 73;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 208;

  typedef enum logic [2:0] {
    ACT_IDLE     = 3'd0,
    ACT_MOVED    = 3'd1,
    ACT_PROCESS  = 3'd2,
    ACT_FINISHED = 3'd3,
    ACT_ENQUEUED = 3'd4,
    ACT_REJECTED = 3'd5
  } action_t;

endpackage
`default_nettype wire

>>> rtl/core/aging_priority_belt_scheduler.sv
// Top level of the aging priority belt scheduler.
`default_nettype none
`include "assert_macros.svh"

// One result word leaves for every input word, in order. An enqueue word and a step that
// finds producers done with both queues empty go straight to the output. A step walks the
// belt through its RAM one entry at a time, each read (S_BRD) before it is checked (S_BCHK)
// because the read data is registered. It then either closes the gap behind an expired
// entry, each entry shifted read (S_BSRD) and then written (S_BSWR), or, when the belt has
// room, scans the waiting queue the same way and closes the gap behind the pick. Input is
// not taken while a word is at work. A result waits in the output register while the next
// word is taken; a word that finishes while that register is still full waits until it is
// read. Configuration writes are taken at any time.
module aging_priority_belt_scheduler #(
  parameter int WAIT_DEPTH = apbs_pkg::WAIT_DEPTH_DEF,
  parameter int BELT_DEPTH = apbs_pkg::BELT_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // package_id[7:0], priority_req[8], now[40:9], producers_done[41], zeros above.
  input  wire logic [apbs_pkg::IN_W-1:0] s_tdata,
  // func[0].
  input  wire logic s_tuser,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // out_id[7:0], out_priority[8], wait_ms[40:9], count_high[72:41], count_low[104:73],
  // sum_wait_high[152:105], sum_wait_low[200:153], zeros above.
  output logic [apbs_pkg::OUT_W-1:0] m_tdata,
  // action[2:0].
  output logic [2:0] m_tuser,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [apbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [apbs_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int WAW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int BAW = (BELT_DEPTH > 1) ? $clog2(BELT_DEPTH) : 1;
  localparam int WCW = $clog2(WAIT_DEPTH + 1);
  localparam int BCW = $clog2(BELT_DEPTH + 1);
  localparam int IW0 = (WCW > BCW) ? WCW : BCW;
  localparam int IW  = ((IW0 > 4) ? IW0 : 4) + 1;
  localparam int PW  = apbs_pkg::PKG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_BRD, S_BCHK, S_STAT, S_BSRD, S_BSWR, S_DECIDE,
    S_WRD, S_WCHK, S_WSRD, S_WSWR, S_BWR, S_OUT
  } state_t;

  state_t state;
  logic [15:0] dwell_limit, move_delay, process_delay;
  logic [19:0] starve_limit;
  logic [3:0]  belt_capacity;
  logic [WCW-1:0] wait_count;
  logic [BCW-1:0] belt_count;
  logic [31:0] high_count, low_count;
  logic [47:0] high_wait_sum, low_wait_sum;
  logic [IW-1:0] idx, pick;
  logic [31:0] now_r;
  logic [PW-1:0] pick_pkg;
  logic        high_found;
  apbs_pkg::action_t res_action;
  logic [7:0]  res_id;
  logic        res_prio;
  logic [31:0] res_wait;

  logic [IW-1:0] wc_ext, bc_ext, idx_p1, idx_p2;
  logic [PW-1:0] w_rdata, w_wdata;
  logic [apbs_pkg::BELT_W-1:0] b_rdata, b_wdata;
  logic          w_we, b_we;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [BAW-1:0] b_waddr, b_raddr;
  logic [32:0] belt_el, wait_el, done_t, entry_sum;
  logic [33:0] wait_diff;
  logic        expired, starved, room;
  logic [31:0] wait_val, entry_time;
  logic [48:0] sum_h, sum_l;
  logic [7:0]  in_id;
  logic        in_prio, in_done;
  logic [31:0] in_now;

  assign in_id   = s_tdata[7:0];
  assign in_prio = s_tdata[8];
  assign in_now  = s_tdata[40:9];
  assign in_done = s_tdata[41];
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign wc_ext = IW'(wait_count);
  assign bc_ext = IW'(belt_count);
  assign idx_p1 = idx + IW'(1);
  assign idx_p2 = idx + IW'(2);

  assign belt_el   = {1'b0, now_r} - {1'b0, b_rdata[72:41]};
  assign expired   = !belt_el[32] && (belt_el[31:0] >= {16'd0, dwell_limit});
  assign done_t    = {1'b0, now_r} + {17'd0, process_delay};
  assign wait_diff = {1'b0, done_t} - {2'b0, b_rdata[40:9]};
  assign wait_val  = wait_diff[33] ? 32'd0 : (wait_diff[32] ? 32'hFFFF_FFFF : wait_diff[31:0]);
  assign wait_el   = {1'b0, now_r} - {1'b0, w_rdata[40:9]};
  assign starved   = !w_rdata[8] && !wait_el[32] && (wait_el[31:0] >= {12'd0, starve_limit});
  assign entry_sum = {1'b0, now_r} + {17'd0, move_delay};
  assign entry_time = entry_sum[32] ? 32'hFFFF_FFFF : entry_sum[31:0];
  assign room = (bc_ext < IW'(belt_capacity)) && (bc_ext < IW'(BELT_DEPTH));
  assign sum_h = {1'b0, high_wait_sum} + {17'd0, res_wait};
  assign sum_l = {1'b0, low_wait_sum} + {17'd0, res_wait};

  always_comb begin
    w_we    = 1'b0;
    w_waddr = idx[WAW-1:0];
    w_wdata = w_rdata;
    w_raddr = (state == S_WSRD) ? idx_p1[WAW-1:0] : idx[WAW-1:0];
    b_we    = 1'b0;
    b_waddr = idx[BAW-1:0];
    b_wdata = b_rdata;
    b_raddr = (state == S_BSRD) ? idx_p1[BAW-1:0] : idx[BAW-1:0];
    unique case (state)
      S_IDLE: begin
        w_we    = s_tvalid && !s_tuser && (wait_count < WCW'(WAIT_DEPTH));
        w_waddr = wait_count[WAW-1:0];
        w_wdata = {in_now, in_prio, in_id};
      end
      S_WSWR: w_we = 1'b1;
      S_BSWR: b_we = 1'b1;
      S_BWR: begin
        b_we    = 1'b1;
        b_waddr = belt_count[BAW-1:0];
        b_wdata = {entry_time, pick_pkg};
      end
      default: ;
    endcase
  end

  apbs_ram #(.WIDTH(PW), .DEPTH(WAIT_DEPTH)) u_wait_ram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  apbs_ram #(.WIDTH(apbs_pkg::BELT_W), .DEPTH(BELT_DEPTH)) u_belt_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      dwell_limit   <= apbs_pkg::DWELL_RST;
      starve_limit  <= apbs_pkg::STARVE_RST;
      belt_capacity <= apbs_pkg::CAP_RST;
      move_delay    <= apbs_pkg::MOVE_RST;
      process_delay <= apbs_pkg::PROCESS_RST;
      wait_count    <= '0;
      belt_count    <= '0;
      high_count    <= '0;
      low_count     <= '0;
      high_wait_sum <= '0;
      low_wait_sum  <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          apbs_pkg::REG_DWELL:   dwell_limit   <= cfg_data[15:0];
          apbs_pkg::REG_STARVE:  starve_limit  <= cfg_data;
          apbs_pkg::REG_CAP:     belt_capacity <= cfg_data[3:0];
          apbs_pkg::REG_MOVE:    move_delay    <= cfg_data[15:0];
          apbs_pkg::REG_PROCESS: process_delay <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            now_r    <= in_now;
            idx      <= '0;
            res_id   <= s_tuser ? 8'd0 : in_id;
            res_prio <= s_tuser ? 1'b0 : in_prio;
            res_wait <= 32'd0;
            if (!s_tuser) begin
              if (wait_count < WCW'(WAIT_DEPTH)) begin
                wait_count <= wait_count + WCW'(1);
                res_action <= apbs_pkg::ACT_ENQUEUED;
              end else begin
                res_action <= apbs_pkg::ACT_REJECTED;
              end
              state <= S_OUT;
            end else if (in_done && wait_count == '0 && belt_count == '0) begin
              res_action <= apbs_pkg::ACT_FINISHED;
              state      <= S_OUT;
            end else if (belt_count != '0) begin
              state <= S_BRD;
            end else begin
              state <= S_DECIDE;
            end
          end
        end
        S_BRD: state <= S_BCHK;
        S_BCHK: begin
          if (expired) begin
            res_action <= apbs_pkg::ACT_PROCESS;
            res_id     <= b_rdata[7:0];
            res_prio   <= b_rdata[8];
            res_wait   <= wait_val;
            state      <= S_STAT;
          end else if (idx_p1 < bc_ext) begin
            idx   <= idx_p1;
            state <= S_BRD;
          end else begin
            state <= S_DECIDE;
          end
        end
        S_STAT: begin
          if (res_prio) begin
            if (high_count != 32'hFFFF_FFFF) high_count <= high_count + 32'd1;
            high_wait_sum <= sum_h[48] ? 48'hFFFF_FFFF_FFFF : sum_h[47:0];
          end else begin
            if (low_count != 32'hFFFF_FFFF) low_count <= low_count + 32'd1;
            low_wait_sum <= sum_l[48] ? 48'hFFFF_FFFF_FFFF : sum_l[47:0];
          end
          if (idx_p1 < bc_ext) begin
            state <= S_BSRD;
          end else begin
            belt_count <= belt_count - BCW'(1);
            state      <= S_OUT;
          end
        end
        S_BSRD: state <= S_BSWR;
        S_BSWR: begin
          idx <= idx_p1;
          if (idx_p2 < bc_ext) begin
            state <= S_BSRD;
          end else begin
            belt_count <= belt_count - BCW'(1);
            state      <= S_OUT;
          end
        end
        S_DECIDE: begin
          idx        <= '0;
          pick       <= '0;
          high_found <= 1'b0;
          if (wait_count != '0 && room) begin
            state <= S_WRD;
          end else begin
            res_action <= apbs_pkg::ACT_IDLE;
            state      <= S_OUT;
          end
        end
        S_WRD: state <= S_WCHK;
        S_WCHK: begin
          if (idx == '0 || starved || (w_rdata[8] && !high_found)) begin
            pick_pkg <= w_rdata;
          end
          if (starved) begin
            pick <= idx;
          end else if (w_rdata[8] && !high_found) begin
            high_found <= 1'b1;
            pick       <= idx;
          end
          if (starved || !(idx_p1 < wc_ext)) begin
            idx   <= (starved || (w_rdata[8] && !high_found)) ? idx : pick;
            state <= S_WSRD;
          end else begin
            idx   <= idx_p1;
            state <= S_WRD;
          end
        end
        S_WSRD: begin
          if (idx_p1 < wc_ext) begin
            state <= S_WSWR;
          end else begin
            state <= S_BWR;
          end
        end
        S_WSWR: begin
          idx   <= idx_p1;
          state <= S_WSRD;
        end
        S_BWR: begin
          res_action <= apbs_pkg::ACT_MOVED;
          res_id     <= pick_pkg[7:0];
          res_prio   <= pick_pkg[8];
          res_wait   <= 32'd0;
          belt_count <= belt_count + BCW'(1);
          wait_count <= wait_count - WCW'(1);
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_action;
            m_tdata  <= {7'd0, low_wait_sum, high_wait_sum, low_count, high_count,
                         res_wait, res_prio, res_id};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `APBS_CHECK(a_belt_bound, clk, rst, (bc_ext <= IW'(BELT_DEPTH)), "belt count past depth")
  `APBS_CHECK(a_wait_bound, clk, rst, (wc_ext <= IW'(WAIT_DEPTH)), "wait count past depth")
  `APBS_CHECK(a_move_room, clk, rst,
              (state == S_BWR) |-> (bc_ext < IW'(BELT_DEPTH) && wc_ext != '0),
              "move without room")
  `APBS_CHECK(a_busy, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "input taken while busy")
endmodule
`default_nettype wire

>>> rtl/core/apbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module apbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> dv/tb_aging_priority_belt_scheduler.sv
// Self-checking testbench of the aging priority belt scheduler with a predicting scoreboard.
module tb_aging_priority_belt_scheduler;
  localparam int CDW = apbs_pkg::CFG_DATA_W;

  typedef struct {
    logic [7:0]  id;
    logic        prio;
    logic [31:0] created;
  } parcel_t;

  typedef struct {
    apbs_pkg::action_t act;
    logic [7:0]  id;
    logic        prio;
    logic [31:0] wait_ms;
    logic [31:0] cnt_high;
    logic [31:0] cnt_low;
    logic [47:0] sum_high;
    logic [47:0] sum_low;
  } outcome_t;

  class belt_scoreboard;
    logic [15:0] dwell;
    logic [19:0] starve;
    logic [3:0]  capacity;
    logic [15:0] move_ofs;
    logic [15:0] proc_ofs;
    parcel_t     waiting[16];
    int          n_wait;
    parcel_t     on_belt[8];
    logic [31:0] entered[8];
    int          n_belt;
    longint      cnt_high, cnt_low, sum_high, sum_low;
    outcome_t    awaited[$];
    int          errors;
    int          seen[6];

    function new();
      dwell = apbs_pkg::DWELL_RST; starve = apbs_pkg::STARVE_RST;
      capacity = apbs_pkg::CAP_RST;
      move_ofs = apbs_pkg::MOVE_RST; proc_ofs = apbs_pkg::PROCESS_RST;
      n_wait = 0; n_belt = 0; errors = 0;
      cnt_high = 0; cnt_low = 0; sum_high = 0; sum_low = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void set_reg(logic [apbs_pkg::CFG_IDX_W-1:0] idx,
                          logic [apbs_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        apbs_pkg::REG_DWELL:   dwell = val[15:0];
        apbs_pkg::REG_STARVE:  starve = val[19:0];
        apbs_pkg::REG_CAP:     capacity = val[3:0];
        apbs_pkg::REG_MOVE:    move_ofs = val[15:0];
        apbs_pkg::REG_PROCESS: proc_ofs = val[15:0];
        default: ;
      endcase
    endfunction

    function longint sat(longint a, longint b, longint lim);
      return (a + b > lim) ? lim : a + b;
    endfunction

    function void note_word(logic f, logic [apbs_pkg::IN_W-1:0] d);
      logic [7:0] id;
      logic prio, done;
      logic [31:0] now;
      outcome_t r;
      int cap, ready, pick;
      longint el, w, entry;
      parcel_t p;
      id = d[7:0]; prio = d[8]; now = d[40:9]; done = d[41];
      r.act = apbs_pkg::ACT_IDLE; r.id = 0; r.prio = 0; r.wait_ms = 0;
      if (!f) begin
        r.id = id; r.prio = prio;
        if (n_wait >= 16) r.act = apbs_pkg::ACT_REJECTED;
        else begin
          waiting[n_wait] = '{id, prio, now};
          n_wait++;
          r.act = apbs_pkg::ACT_ENQUEUED;
        end
      end else if (done && n_wait == 0 && n_belt == 0) begin
        r.act = apbs_pkg::ACT_FINISHED;
      end else begin
        cap = (capacity > 8) ? 8 : capacity;
        ready = -1;
        for (int i = 0; i < n_belt; i++) begin
          el = longint'(now) - longint'(entered[i]);
          if (el >= longint'(dwell)) begin ready = i; break; end
        end
        if (ready >= 0) begin
          p = on_belt[ready];
          w = longint'(now) + longint'(proc_ofs) - longint'(p.created);
          if (w < 0) w = 0;
          if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
          for (int i = ready; i + 1 < n_belt; i++) begin
            on_belt[i] = on_belt[i+1];
            entered[i] = entered[i+1];
          end
          n_belt--;
          if (p.prio) begin
            cnt_high = sat(cnt_high, 1, 64'hFFFF_FFFF);
            sum_high = sat(sum_high, w, 64'hFFFF_FFFF_FFFF);
          end else begin
            cnt_low = sat(cnt_low, 1, 64'hFFFF_FFFF);
            sum_low = sat(sum_low, w, 64'hFFFF_FFFF_FFFF);
          end
          r.act = apbs_pkg::ACT_PROCESS; r.id = p.id; r.prio = p.prio;
          r.wait_ms = w[31:0];
        end else if (n_wait > 0 && n_belt < cap) begin
          pick = -1;
          for (int i = 0; i < n_wait; i++) begin
            if (!waiting[i].prio) begin
              w = longint'(now) - longint'(waiting[i].created);
              if (w >= longint'(starve)) begin pick = i; break; end
            end
          end
          if (pick < 0) begin
            for (int i = 0; i < n_wait; i++) begin
              if (waiting[i].prio) begin pick = i; break; end
            end
          end
          if (pick < 0) pick = 0;
          p = waiting[pick];
          for (int i = pick; i + 1 < n_wait; i++) waiting[i] = waiting[i+1];
          n_wait--;
          entry = longint'(now) + longint'(move_ofs);
          if (entry > 64'hFFFF_FFFF) entry = 64'hFFFF_FFFF;
          on_belt[n_belt] = p;
          entered[n_belt] = entry[31:0];
          n_belt++;
          r.act = apbs_pkg::ACT_MOVED; r.id = p.id; r.prio = p.prio;
        end
      end
      r.cnt_high = cnt_high[31:0]; r.cnt_low = cnt_low[31:0];
      r.sum_high = sum_high[47:0]; r.sum_low = sum_low[47:0];
      awaited = {awaited, r};
    endfunction

    function void cmp(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_word(logic [2:0] act, logic [apbs_pkg::OUT_W-1:0] d);
      outcome_t e;
      if (awaited.size() == 0) begin
        $display("%0t unexpected result word: expected none actual action %0d", $time, act);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (act < 6) seen[act]++;
      cmp("action", 64'(e.act), 64'(act));
      cmp("out_id", 64'(e.id), 64'(d[7:0]));
      cmp("out_priority", 64'(e.prio), 64'(d[8]));
      cmp("wait_ms", 64'(e.wait_ms), 64'(d[40:9]));
      cmp("count_high", 64'(e.cnt_high), 64'(d[72:41]));
      cmp("count_low", 64'(e.cnt_low), 64'(d[104:73]));
      cmp("sum_wait_high", 64'(e.sum_high), 64'(d[152:105]));
      cmp("sum_wait_low", 64'(e.sum_low), 64'(d[200:153]));
      cmp("padding", 64'd0, 64'(d[apbs_pkg::OUT_W-1:201]));
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [apbs_pkg::IN_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [apbs_pkg::OUT_W-1:0] m_tdata;
  logic [2:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [apbs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [apbs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  belt_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int cycles = 0;
  int n_items = 0;
  logic [31:0] t_ms = 0;

  aging_priority_belt_scheduler dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_word(m_tuser, m_tdata);
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_word(input logic f, input logic [7:0] id, input logic prio,
                           input logic [31:0] now, input logic done);
    logic [apbs_pkg::IN_W-1:0] d;
    d = {6'b0, done, now, prio, id};
    s_tuser <= f;
    s_tdata <= d;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(f, d);
    n_items++;
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() > 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [apbs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [apbs_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic setup(input int dw, input int st, input int cap, input int mv, input int pr);
    write_reg(apbs_pkg::REG_DWELL, CDW'(dw));
    write_reg(apbs_pkg::REG_STARVE, CDW'(st));
    write_reg(apbs_pkg::REG_CAP, CDW'(cap));
    write_reg(apbs_pkg::REG_MOVE, CDW'(mv));
    write_reg(apbs_pkg::REG_PROCESS, CDW'(pr));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_words(input int count, input int jump);
    int sel;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 2) t_ms = $urandom();
      else if (sel < 5) t_ms = t_ms - $urandom_range(0, 2000);
      else if (sel < 10) t_ms = t_ms + $urandom_range(0, 70000);
      else t_ms = t_ms + $urandom_range(0, jump);
      if ($urandom_range(99) < 45)
        send_word(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)), t_ms,
                  1'($urandom_range(1)));
      else
        send_word(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)), t_ms,
                  $urandom_range(99) < 30);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset settings.
    send_word(1'b1, 8'h00, 1'b0, 32'd0, 1'b1);
    send_word(1'b1, 8'hFF, 1'b1, 32'd0, 1'b0);
    send_word(1'b0, 8'h00, 1'b0, 32'd0, 1'b0);
    send_word(1'b0, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
    for (int k = 0; k < 15; k++) send_word(1'b0, 8'(k + 1), k[0], 32'(k * 10), 1'b0);
    send_word(1'b1, 8'h00, 1'b0, 32'd6000, 1'b0);
    send_word(1'b1, 8'h00, 1'b0, 32'd6100, 1'b0);
    send_word(1'b1, 8'h00, 1'b0, 32'd7000, 1'b1);
    send_word(1'b1, 8'h00, 1'b0, 32'hFFFF_FFF0, 1'b0);
    send_word(1'b1, 8'h00, 1'b0, 32'd100, 1'b0);
    t_ms = 32'd8000;
    random_words(336, 300);
    drain();

    send_idle = 61; recv_stall = 0;
    setup(0, 0, 8, 0, 0);
    random_words(230, 50);
    drain();

    send_idle = 0; recv_stall = 61;
    setup(65535, 1048575, 1, 65535, 65535);
    random_words(230, 30000);
    drain();

    send_idle = 22; recv_stall = 22;
    setup(300, 2000, 0, 100, 50);
    random_words(120, 300);
    drain();
    setup(200, 1500, 15, 1000, 500);
    random_words(230, 400);
    drain();

    send_idle = 0; recv_stall = 0;
    setup(550, 6000, 3, 420, 270);
    random_words(230, 300);
    drain();

    repeat (20) @(posedge clk);
    $display("Run covered %0d input words over six setting phases with sender and receiver gaps.",
             n_items);
    $display("Results: %0d idle, %0d moved, %0d processed, %0d finished, %0d enqueued, %0d full.",
             sb.seen[0], sb.seen[1], sb.seen[2], sb.seen[3], sb.seen[4], sb.seen[5]);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
